// ===== hw/rtl/mctt_pkg.sv =====
// ----------------------------------------------------------------------------
// mctt_pkg: shared definitions for the multi-channel tick timer
// Field widths, command and state codes, and the count unit result type.
// ----------------------------------------------------------------------------
package mctt_pkg;

    // Parameter defaults.
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;

    // Fixed field widths.
    localparam int CMD_W     = 2;
    localparam int CH_W      = 4;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ONESHOT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PERIODIC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DISARM   = 2'd3;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // Per-channel verdict from the count unit.
    typedef struct packed {
        logic expire;      // the channel reached zero on this tick
        logic keep_armed;  // the channel stays armed after this tick
        logic write_en;    // the entry must be written back
    } t_cnt_res;

endpackage

// ===== hw/rtl/mctt_mem.sv =====
// ----------------------------------------------------------------------------
// mctt_mem: channel state memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mctt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 33,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mctt_cnt_unit.sv =====
// ----------------------------------------------------------------------------
// mctt_cnt_unit: shared countdown unit
// Decrements one channel's count per use and decides expiry and reload.
// ----------------------------------------------------------------------------
module mctt_cnt_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_armed,
    input  logic                   i_periodic,
    input  logic [COUNT_WIDTH-1:0] i_reload,
    input  logic [COUNT_WIDTH-1:0] i_remaining,
    output logic [COUNT_WIDTH-1:0] o_next_count,
    output mctt_pkg::t_cnt_res     o_res
);
    import mctt_pkg::*;

    t_cnt_res w_res;

    always_comb begin
        w_res        = '0;
        o_next_count = i_remaining;
        if (i_armed) begin
            w_res.write_en = 1'b1;
            if (i_remaining <= COUNT_WIDTH'(1)) begin
                w_res.expire = 1'b1;
                // A periodic channel with a nonzero period reloads; otherwise it stops.
                if (i_periodic && (i_reload != '0)) begin
                    o_next_count     = i_reload;
                    w_res.keep_armed = 1'b1;
                end else begin
                    o_next_count = '0;
                end
            end else begin
                o_next_count     = i_remaining - COUNT_WIDTH'(1);
                w_res.keep_armed = 1'b1;
            end
        end
    end

    assign o_res = w_res;

endmodule

// ===== hw/rtl/multi_channel_tick_timer_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_tick_timer_core: bank of one-shot and periodic countdown timers
// Commands arm, disarm or tick the channels; a tick scans the channels in use
// one per cycle unless output holds it; each expiry becomes an output item.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------
//  in        i_in_valid / o_in_stall      i_command, i_channel, i_timeout_ticks
//  out       o_out_valid / i_out_stall    o_expired_channel, o_last
//  cfg       i_cfg_valid / o_cfg_ready    i_cfg_data (channels in use)
//
// A tick item scans N channels, where N is the in-use count limited to
// NUM_CHANNELS: the channel memory has one read and one write port, so the
// scan visits one channel per cycle while the output does not hold it.
// A stalled output item holds the scan only when another expiry must move up
// behind it. Reset is synchronous and active low; it disarms every channel and
// sets the in-use count to 16. The input side is stalled whenever a tick is in
// progress.
// ----------------------------------------------------------------------------
module multi_channel_tick_timer_core #(
    parameter int NUM_CHANNELS = mctt_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_WIDTH  = mctt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [mctt_pkg::CMD_W-1:0]     i_command,
    input  logic [mctt_pkg::CH_W-1:0]      i_channel,
    input  logic [mctt_pkg::TIMEOUT_W-1:0] i_timeout_ticks,
    // Expiry channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [mctt_pkg::CH_W-1:0]      o_expired_channel,
    output logic                           o_last,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mctt_pkg::CFG_W-1:0]     i_cfg_data
);
    import mctt_pkg::*;

    // Channel index width, scan counter width (holds NUM_CHANNELS itself),
    // and memory word width {periodic, reload, remaining}.
    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LW = $clog2(NUM_CHANNELS + 1);
    localparam int WW = 2 * COUNT_WIDTH + 1;
    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    // Control and status registers.
    logic [1:0]              r_state,      n_state;
    logic [LW-1:0]           r_idx,        n_idx;
    logic [LW-1:0]           r_limit,      n_limit;
    logic [NUM_CHANNELS-1:0] r_armed,      n_armed;
    logic [CFG_W-1:0]        r_cfg;
    // The most recent expiry is held back until we know whether it is the last.
    logic                    r_hold_valid, n_hold_valid;
    logic [CH_W-1:0]         r_hold_ch,    n_hold_ch;
    // Output register.
    logic                    r_out_valid,  n_out_valid;
    logic [CH_W-1:0]         r_out_ch,     n_out_ch;
    logic                    r_out_last,   n_out_last;

    logic                   w_in_acc;
    logic                   w_ch_ok;
    logic [COUNT_WIDTH-1:0] w_t;
    logic [LW-1:0]          w_lim;
    logic                   w_out_busy;
    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    logic [WW-1:0]          w_wdata;
    logic [WW-1:0]          w_rdata;
    logic [COUNT_WIDTH-1:0] w_next_count;
    t_cnt_res               w_res;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_ch_ok     = (32'(i_channel) < NUM_CHANNELS);
    assign w_out_busy  = r_out_valid && i_out_stall;

    // Timeouts wider than the counter saturate to its largest value.
    assign w_t = (64'(i_timeout_ticks) > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX)
                                                     : COUNT_WIDTH'(i_timeout_ticks);
    // The in-use count saturates at the number of channels built.
    assign w_lim = (32'(r_cfg) > NUM_CHANNELS) ? LW'(NUM_CHANNELS) : LW'(r_cfg);

    mctt_mem #(
        .DEPTH (NUM_CHANNELS),
        .WIDTH (WW),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    mctt_cnt_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cnt (
        .i_armed      (r_armed[r_idx[IW-1:0]]),
        .i_periodic   (w_rdata[WW-1]),
        .i_reload     (w_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH]),
        .i_remaining  (w_rdata[COUNT_WIDTH-1:0]),
        .o_next_count (w_next_count),
        .o_res        (w_res)
    );

    // Sequencer. The memory always reads the entry at n_idx, so the entry for
    // r_idx is on the read port whenever the scan sits on that channel.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_limit      = r_limit;
        n_armed      = r_armed;
        n_hold_valid = r_hold_valid;
        n_hold_ch    = r_hold_ch;
        n_out_valid  = w_out_busy;
        n_out_ch     = r_out_ch;
        n_out_last   = r_out_last;
        w_we         = 1'b0;
        w_waddr      = r_idx[IW-1:0];
        w_wdata      = {w_rdata[WW-1], w_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH], w_next_count};

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == CMD_TICK) begin
                        n_limit = w_lim;
                        n_idx   = '0;
                        n_state = (w_lim == '0) ? ST_FLUSH : ST_SCAN;
                    end else if (w_ch_ok) begin
                        if (i_command == CMD_DISARM) begin
                            // Disarm keeps the period and the mode.
                            n_armed[IW'(i_channel)] = 1'b0;
                        end else begin
                            // Arming with zero records the setting but leaves it disarmed.
                            w_we    = 1'b1;
                            w_waddr = IW'(i_channel);
                            w_wdata = {(i_command == CMD_PERIODIC), w_t, w_t};
                            n_armed[IW'(i_channel)] = (w_t != '0);
                        end
                    end
                end
            end
            ST_SCAN: begin
                // Wait only when a second expiry must push the held one into a
                // full output register.
                if (!(w_res.expire && r_hold_valid && w_out_busy)) begin
                    w_we = w_res.write_en;
                    n_armed[r_idx[IW-1:0]] = w_res.keep_armed;
                    if (w_res.expire) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_ch    = r_hold_ch;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_ch    = CH_W'(r_idx);
                    end
                    if (r_idx == r_limit - 1'b1) begin
                        n_state = ST_FLUSH;
                    end
                    n_idx = LW'(r_idx + 1'b1);
                end
            end
            ST_FLUSH: begin
                if (r_hold_valid) begin
                    if (!w_out_busy) begin
                        n_out_valid  = 1'b1;
                        n_out_ch     = r_hold_ch;
                        n_out_last   = 1'b1;
                        n_hold_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_limit      <= '0;
            r_armed      <= '0;
            r_cfg        <= CFG_RESET;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_limit      <= n_limit;
            r_armed      <= n_armed;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_ch  <= n_hold_ch;
        r_out_ch   <= n_out_ch;
        r_out_last <= n_out_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_expired_channel = r_out_ch;
    assign o_last            = r_out_last;

    // A held expiry never outlives its tick.
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("held expiry left over after a tick");

    // The scan never runs past the in-use count.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx < r_limit))
        else $error("scan index beyond the channels in use");

    // Closing a tick with a held expiry presents it as the last item.
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_hold_valid && !w_out_busy)
        |=> (o_out_valid && o_last))
        else $error("final expiry of a tick not flagged last");

    // A new expiry may only push the held one out while the output has room.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && w_res.expire && r_hold_valid && w_out_busy)
        |=> (r_idx == $past(r_idx)))
        else $error("scan advanced over a full output register");

endmodule
